>>> rtl/rsis_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsis_pkg
// Shared types and constants of the reservation station issue scheduler.
// ----------------------------------------------------------------------------
package rsis_pkg;

  localparam int unsigned TAG_BITS = 16;
  localparam int unsigned ALU_DEPTH = 8;
  localparam int unsigned MEM_DEPTH = 8;
  localparam int unsigned BR_DEPTH = 4;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned NUM_LAT = 5;

  typedef logic [TAG_BITS-1:0] tag_t;
  typedef logic [5:0] lat_t;

  localparam logic [1:0] KIND_ENQ = 2'd0;
  localparam logic [1:0] KIND_MARK = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  localparam logic [1:0] UNIT_ALU = 2'd0;
  localparam logic [1:0] UNIT_MEM = 2'd1;
  localparam logic [1:0] UNIT_BR = 2'd2;

  localparam logic [1:0] CLS_PLAIN = 2'd0;
  localparam logic [1:0] CLS_MUL = 2'd1;
  localparam logic [1:0] CLS_DIV = 2'd2;

  localparam logic [2:0] EV_ACCEPT = 3'd0;
  localparam logic [2:0] EV_REJECT = 3'd1;
  localparam logic [2:0] EV_ISSUE = 3'd2;
  localparam logic [2:0] EV_DONE = 3'd3;
  localparam logic [2:0] EV_MARK = 3'd4;
  localparam logic [2:0] EV_NONE = 3'd5;

  localparam logic [2:0] REG_ALU = 3'd0;
  localparam logic [2:0] REG_MUL = 3'd1;
  localparam logic [2:0] REG_DIV = 3'd2;
  localparam logic [2:0] REG_MEM = 3'd3;
  localparam logic [2:0] REG_BR = 3'd4;

  localparam lat_t LAT_ALU_RST = 6'd1;
  localparam lat_t LAT_MUL_RST = 6'd3;
  localparam lat_t LAT_DIV_RST = 6'd35;
  localparam lat_t LAT_MEM_RST = 6'd2;
  localparam lat_t LAT_BR_RST = 6'd1;

  // One classified command handed from the front to the back.
  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] unit;
    tag_t       tag;
    logic [1:0] cls;
    logic       is_load;
    logic       s1;
    logic       s2;
    logic       which;
    logic       pend;
    tag_t       stag;
  } cmd_t;

endpackage
`default_nettype wire

>>> rtl/reservation_station_issue_scheduler_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// reservation_station_issue_scheduler_top
// An enqueue or mark result passes the command queue, the back end's result
// register and the output register on its way to the ports; tick results
// follow at most one per cycle. The back end handles enqueue and mark in its
// idle state and a tick in steps (latch, four slot countdown steps, four slot
// issue steps). A four-entry command queue takes a transfer every cycle until
// full; busy is high while full. The receiver cannot stall. Reset clears the
// queues, counts and slot busy bits and loads the default latencies.
// ----------------------------------------------------------------------------
module reservation_station_issue_scheduler_top (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start,
  output logic                busy,
  input  wire [1:0]           kind_i,
  input  wire [1:0]           unit_i,
  input  rsis_pkg::tag_t      op_tag_i,
  input  wire [1:0]           alu_class_i,
  input  wire                 is_load_i,
  input  wire                 src1_ready_i,
  input  wire                 src2_ready_i,
  input  wire                 which_source_i,
  input  wire                 store_pending_i,
  input  rsis_pkg::tag_t      oldest_store_tag_i,
  input  wire                 cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire [2:0]           cfg_index_i,
  input  wire [5:0]           cfg_data_i,
  output logic                res_strobe_o,
  output logic [2:0]          event_res_o,
  output logic [1:0]          slot_o,
  output rsis_pkg::tag_t      tag_o,
  output logic                last_o
);
  import rsis_pkg::*;

  cmd_t in_cmd, q_cmd;
  logic full, empty, pop, pv, pl;
  logic [2:0] pe;
  logic [1:0] ps;
  tag_t pt;

  assign in_cmd = '{kind_i, unit_i, op_tag_i, alu_class_i, is_load_i, src1_ready_i,
                    src2_ready_i, which_source_i, store_pending_i, oldest_store_tag_i};
  assign busy = full;
  assign cfg_ready_o = 1'b1;

  rsis_front u_front (
    .clk_i, .rst_ni, .push_i(start && !full), .cmd_i(in_cmd), .pop_i(pop),
    .full_o(full), .empty_o(empty), .cmd_o(q_cmd)
  );

  rsis_back u_back (
    .clk_i, .rst_ni, .have_i(!empty), .cmd_i(q_cmd), .pop_o(pop),
    .cfg_we_i(cfg_valid_i), .cfg_idx_i(cfg_index_i), .cfg_val_i(cfg_data_i),
    .res_valid_o(pv), .res_event_o(pe), .res_slot_o(ps), .res_tag_o(pt), .res_last_o(pl)
  );

  rsis_outbuf u_out (
    .clk_i, .rst_ni, .v_i(pv), .e_i(pe), .s_i(ps), .t_i(pt), .l_i(pl),
    .v_o(res_strobe_o), .e_o(event_res_o), .s_o(slot_o), .t_o(tag_o), .l_o(last_o)
  );

endmodule
`default_nettype wire

>>> rtl/rsis_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsis_front
// Command queue: takes start transfers, normalizes unit and class codes.
// ----------------------------------------------------------------------------
module rsis_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  rsis_pkg::cmd_t      cmd_i,
  input  wire                 pop_i,
  output logic                full_o,
  output logic                empty_o,
  output rsis_pkg::cmd_t      cmd_o
);
  import rsis_pkg::*;

  localparam int unsigned PW = $clog2(FIFO_DEPTH);

  cmd_t mem_q [FIFO_DEPTH];
  logic [PW-1:0] wp_q, rp_q;
  logic [PW:0] cnt_q;
  cmd_t norm;

  always_comb begin
    norm = cmd_i;
    if (cmd_i.unit > UNIT_BR) norm.unit = UNIT_BR;
    if (cmd_i.cls > CLS_DIV) norm.cls = CLS_PLAIN;
  end

  assign full_o = (cnt_q == (PW+1)'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign cmd_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= norm;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + PW'(1);
      if (pop_i) rp_q <= rp_q + PW'(1);
      cnt_q <= cnt_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
    end
  end

endmodule
`default_nettype wire

>>> rtl/rsis_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsis_back
// Queues, execution slots and the result sequencer. At most one result per cycle.
// ----------------------------------------------------------------------------
module rsis_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 have_i,
  input  rsis_pkg::cmd_t      cmd_i,
  output logic                pop_o,
  input  wire                 cfg_we_i,
  input  wire [2:0]           cfg_idx_i,
  input  wire [5:0]           cfg_val_i,
  output logic                res_valid_o,
  output logic [2:0]          res_event_o,
  output logic [1:0]          res_slot_o,
  output rsis_pkg::tag_t      res_tag_o,
  output logic                res_last_o
);
  import rsis_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_DONE  = 3'b010,
    ST_ISSUE = 3'b100
  } state_e;

  typedef struct packed {
    tag_t       tag;
    logic [1:0] aux;
    logic       r1;
    logic       r2;
  } ent_t;

  localparam int unsigned AW = $clog2(ALU_DEPTH);
  localparam int unsigned MW = $clog2(MEM_DEPTH);
  localparam int unsigned BW = $clog2(BR_DEPTH);

  ent_t alu_q [ALU_DEPTH];
  ent_t mem_q [MEM_DEPTH];
  ent_t br_q  [BR_DEPTH];
  logic [AW:0] acnt_q;
  logic [MW:0] mcnt_q;
  logic [BW:0] bcnt_q;

  logic [3:0] busy_q;
  lat_t       rem_q [4];
  tag_t       stag_q [4];
  lat_t       lat_q [NUM_LAT];

  state_e     state_q;
  logic [1:0] si_q;
  logic       any_q;
  cmd_t       cur_q;

  // Registered result.
  logic       rv_q, rl_q;
  logic [2:0] re_q;
  logic [1:0] rs_q;
  tag_t       rt_q;

  // Per-queue oldest eligible search and mark search.
  logic       a_hit, a_two, m_hit, b_hit;
  logic [AW-1:0] a_idx;
  logic [MW-1:0] m_idx;
  logic [BW-1:0] b_idx;
  logic       ma_hit, mm_hit, mb_hit;
  logic [AW-1:0] ma_idx;
  logic [MW-1:0] mm_idx;
  logic [BW-1:0] mb_idx;

  always_comb begin
    a_hit = 1'b0; a_two = 1'b0; a_idx = '0; ma_hit = 1'b0; ma_idx = '0;
    for (int i = ALU_DEPTH-1; i >= 0; i--) begin
      if ((AW+1)'(i) < acnt_q) begin
        if (alu_q[i].r1 && alu_q[i].r2) begin
          if (a_hit) a_two = 1'b1;
          a_hit = 1'b1; a_idx = AW'(i);
        end
        if (alu_q[i].tag == cmd_i.tag) begin
          ma_hit = 1'b1; ma_idx = AW'(i);
        end
      end
    end
    m_hit = 1'b0; m_idx = '0; mm_hit = 1'b0; mm_idx = '0;
    for (int i = MEM_DEPTH-1; i >= 0; i--) begin
      if ((MW+1)'(i) < mcnt_q) begin
        if (mem_q[i].r1 && mem_q[i].r2 &&
            !(mem_q[i].aux[0] && cur_q.pend && cur_q.stag < mem_q[i].tag)) begin
          m_hit = 1'b1; m_idx = MW'(i);
        end
        if (mem_q[i].tag == cmd_i.tag) begin
          mm_hit = 1'b1; mm_idx = MW'(i);
        end
      end
    end
    b_hit = 1'b0; b_idx = '0; mb_hit = 1'b0; mb_idx = '0;
    for (int i = BR_DEPTH-1; i >= 0; i--) begin
      if ((BW+1)'(i) < bcnt_q) begin
        if (br_q[i].r1 && br_q[i].r2) begin
          b_hit = 1'b1; b_idx = BW'(i);
        end
        if (br_q[i].tag == cmd_i.tag) begin
          mb_hit = 1'b1; mb_idx = BW'(i);
        end
      end
    end
  end

  // Completions and issues still to come in this tick, for the last flag.
  // The queues do not change while slots count down, so the whole issue
  // pattern is known at the start of the tick; slot 1 needs a second
  // eligible ALU entry when slot 0 takes the first.
  logic [3:0] done_m;
  logic [3:0] free_m;
  logic [3:0] iss_m;
  logic       pred0, pred1, any_iss, done_later, iss_later, iss_now;
  always_comb begin
    for (int s = 0; s < 4; s++) begin
      done_m[s] = busy_q[s] && (rem_q[s] <= 6'd1);
      free_m[s] = !busy_q[s] || (2'(s) >= si_q && done_m[s]);
    end
    pred0 = free_m[0] && a_hit;
    pred1 = free_m[1] && (pred0 ? a_two : a_hit);
    any_iss = pred0 || pred1 || (free_m[2] && m_hit) || (free_m[3] && b_hit);
    done_later = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (2'(k) > si_q && done_m[k]) done_later = 1'b1;
    end
    iss_m[0] = !busy_q[0] && a_hit;
    iss_m[1] = !busy_q[1] && a_hit;
    iss_m[2] = !busy_q[2] && m_hit;
    iss_m[3] = !busy_q[3] && b_hit;
    iss_now = iss_m[si_q];
    case (si_q)
      2'd0: iss_later = (!busy_q[1] && (iss_now ? a_two : a_hit)) || iss_m[2] || iss_m[3];
      2'd1: iss_later = iss_m[2] || iss_m[3];
      2'd2: iss_later = iss_m[3];
      default: iss_later = 1'b0;
    endcase
  end

  assign pop_o = have_i && (state_q == ST_IDLE);
  assign res_valid_o = rv_q;
  assign res_event_o = re_q;
  assign res_slot_o = rs_q;
  assign res_tag_o = rt_q;
  assign res_last_o = rl_q;

  lat_t alu_lat;
  always_comb begin
    case (alu_q[a_idx].aux)
      CLS_MUL: alu_lat = lat_q[REG_MUL];
      CLS_DIV: alu_lat = lat_q[REG_DIV];
      default: alu_lat = lat_q[REG_ALU];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && have_i && cmd_i.kind == KIND_ENQ) begin
      case (cmd_i.unit)
        UNIT_ALU:
          if (acnt_q < (AW+1)'(ALU_DEPTH))
            alu_q[acnt_q[AW-1:0]] <= '{cmd_i.tag, cmd_i.cls, cmd_i.s1, cmd_i.s2};
        UNIT_MEM:
          if (mcnt_q < (MW+1)'(MEM_DEPTH))
            mem_q[mcnt_q[MW-1:0]] <= '{cmd_i.tag, {1'b0, cmd_i.is_load}, cmd_i.s1, cmd_i.s2};
        default:
          if (bcnt_q < (BW+1)'(BR_DEPTH))
            br_q[bcnt_q[BW-1:0]] <= '{cmd_i.tag, 2'd0, cmd_i.s1, cmd_i.s2};
      endcase
    end else if (state_q == ST_IDLE && have_i && cmd_i.kind == KIND_MARK) begin
      case (cmd_i.unit)
        UNIT_ALU: if (ma_hit) begin
          if (cmd_i.which) alu_q[ma_idx].r2 <= 1'b1; else alu_q[ma_idx].r1 <= 1'b1;
        end
        UNIT_MEM: if (mm_hit) begin
          if (cmd_i.which) mem_q[mm_idx].r2 <= 1'b1; else mem_q[mm_idx].r1 <= 1'b1;
        end
        default: if (mb_hit) begin
          if (cmd_i.which) br_q[mb_idx].r2 <= 1'b1; else br_q[mb_idx].r1 <= 1'b1;
        end
      endcase
    end else if (state_q == ST_ISSUE && iss_now) begin
      // Shift the queue down over the issued entry, one register per entry.
      case (si_q)
        2'd0, 2'd1: for (int i = 0; i < ALU_DEPTH-1; i++)
          if (AW'(i) >= a_idx) alu_q[i] <= alu_q[i+1];
        2'd2: for (int i = 0; i < MEM_DEPTH-1; i++)
          if (MW'(i) >= m_idx) mem_q[i] <= mem_q[i+1];
        default: for (int i = 0; i < BR_DEPTH-1; i++)
          if (BW'(i) >= b_idx) br_q[i] <= br_q[i+1];
      endcase
    end
    if (state_q == ST_IDLE && have_i && cmd_i.kind == KIND_TICK) cur_q <= cmd_i;
    if (state_q == ST_ISSUE && iss_now) begin
      case (si_q)
        2'd0, 2'd1: begin rem_q[si_q] <= alu_lat; stag_q[si_q] <= alu_q[a_idx].tag; end
        2'd2: begin rem_q[2] <= lat_q[REG_MEM]; stag_q[2] <= mem_q[m_idx].tag; end
        default: begin rem_q[3] <= lat_q[REG_BR]; stag_q[3] <= br_q[b_idx].tag; end
      endcase
    end else if (state_q == ST_DONE && busy_q[si_q] && rem_q[si_q] > 6'd1) begin
      rem_q[si_q] <= rem_q[si_q] - 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      si_q <= '0;
      any_q <= 1'b0;
      acnt_q <= '0; mcnt_q <= '0; bcnt_q <= '0;
      busy_q <= '0;
      rv_q <= 1'b0; rl_q <= 1'b0; re_q <= EV_NONE; rs_q <= '0; rt_q <= '0;
      lat_q[REG_ALU] <= LAT_ALU_RST;
      lat_q[REG_MUL] <= LAT_MUL_RST;
      lat_q[REG_DIV] <= LAT_DIV_RST;
      lat_q[REG_MEM] <= LAT_MEM_RST;
      lat_q[REG_BR]  <= LAT_BR_RST;
    end else begin
      rv_q <= 1'b0;
      rl_q <= 1'b0;
      if (cfg_we_i && cfg_idx_i < 3'(NUM_LAT)) lat_q[cfg_idx_i] <= cfg_val_i;
      case (state_q)
        ST_IDLE: if (have_i) begin
          rv_q <= 1'b1; rs_q <= '0; rt_q <= cmd_i.tag; rl_q <= 1'b1;
          case (cmd_i.kind)
            KIND_ENQ: begin
              re_q <= EV_REJECT;
              case (cmd_i.unit)
                UNIT_ALU: if (acnt_q < (AW+1)'(ALU_DEPTH)) begin
                  re_q <= EV_ACCEPT; acnt_q <= acnt_q + (AW+1)'(1);
                end
                UNIT_MEM: if (mcnt_q < (MW+1)'(MEM_DEPTH)) begin
                  re_q <= EV_ACCEPT; mcnt_q <= mcnt_q + (MW+1)'(1);
                end
                default: if (bcnt_q < (BW+1)'(BR_DEPTH)) begin
                  re_q <= EV_ACCEPT; bcnt_q <= bcnt_q + (BW+1)'(1);
                end
              endcase
            end
            KIND_MARK: begin
              case (cmd_i.unit)
                UNIT_ALU: re_q <= ma_hit ? EV_MARK : EV_NONE;
                UNIT_MEM: re_q <= mm_hit ? EV_MARK : EV_NONE;
                default:  re_q <= mb_hit ? EV_MARK : EV_NONE;
              endcase
            end
            KIND_TICK: begin
              rv_q <= 1'b0; rl_q <= 1'b0;
              state_q <= ST_DONE; si_q <= '0; any_q <= 1'b0;
            end
            default: begin
              re_q <= EV_NONE; rt_q <= '0;
            end
          endcase
        end
        ST_DONE: begin
          if (done_m[si_q]) begin
            busy_q[si_q] <= 1'b0;
            rv_q <= 1'b1; re_q <= EV_DONE; rs_q <= si_q; rt_q <= stag_q[si_q];
            rl_q <= !done_later && !any_iss;
            any_q <= 1'b1;
          end
          si_q <= si_q + 2'd1;
          if (si_q == 2'd3) state_q <= ST_ISSUE;
        end
        default: begin
          if (iss_now) begin
            busy_q[si_q] <= 1'b1;
            rv_q <= 1'b1; re_q <= EV_ISSUE; rs_q <= si_q;
            rl_q <= !iss_later;
            case (si_q)
              2'd0, 2'd1: begin
                rt_q <= alu_q[a_idx].tag; acnt_q <= acnt_q - (AW+1)'(1);
              end
              2'd2: begin rt_q <= mem_q[m_idx].tag; mcnt_q <= mcnt_q - (MW+1)'(1); end
              default: begin rt_q <= br_q[b_idx].tag; bcnt_q <= bcnt_q - (BW+1)'(1); end
            endcase
            any_q <= 1'b1;
          end
          si_q <= si_q + 2'd1;
          if (si_q == 2'd3) begin
            state_q <= ST_IDLE;
            // A tick that neither completes nor issues reports a single EV_NONE result.
            if (!iss_now && !any_q) begin
              rv_q <= 1'b1; re_q <= EV_NONE; rs_q <= '0; rt_q <= '0; rl_q <= 1'b1;
            end
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/rsis_outbuf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsis_outbuf
// Output register stage that drives the result ports.
// ----------------------------------------------------------------------------
module rsis_outbuf (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 v_i,
  input  wire [2:0]           e_i,
  input  wire [1:0]           s_i,
  input  rsis_pkg::tag_t      t_i,
  input  wire                 l_i,
  output logic                v_o,
  output logic [2:0]          e_o,
  output logic [1:0]          s_o,
  output rsis_pkg::tag_t      t_o,
  output logic                l_o
);
  import rsis_pkg::*;

  logic       ov_q, ol_q;
  logic [2:0] oe_q;
  logic [1:0] os_q;
  tag_t       ot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      ol_q <= 1'b0;
      oe_q <= '0; os_q <= '0; ot_q <= '0;
    end else begin
      ov_q <= v_i;
      ol_q <= v_i && l_i;
      oe_q <= e_i;
      os_q <= s_i;
      ot_q <= t_i;
    end
  end

  assign v_o = ov_q;
  assign e_o = oe_q;
  assign s_o = os_q;
  assign t_o = ot_q;
  assign l_o = ol_q;

endmodule
`default_nettype wire

>>> rtl/rsis_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsis_checker
// Port-level checks of the scheduler's result stream.
// ----------------------------------------------------------------------------
module rsis_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        res_strobe_o,
  input wire [2:0]  event_res_o,
  input wire [1:0]  slot_o,
  input wire        last_o
);
  import rsis_pkg::*;

  a_last_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> res_strobe_o) else $error("last without result");

  a_event_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> event_res_o <= EV_NONE) else $error("bad event code");

  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && (event_res_o == EV_ACCEPT || event_res_o == EV_REJECT ||
     event_res_o == EV_MARK || event_res_o == EV_NONE)) |-> slot_o == 2'd0)
    else $error("slot set on non-slot event");

endmodule

bind reservation_station_issue_scheduler_top rsis_checker u_chk (
  .clk_i, .rst_ni, .res_strobe_o, .event_res_o, .slot_o, .last_o
);
`default_nettype wire
